FILE: rtl/core/xvr_pkg.sv
// ----------------------------------------------------------------------------
// xvr_pkg
// Shared types, widths and arithmetic helpers for the XYZ vertex rotation.
// ----------------------------------------------------------------------------
`default_nettype none

package xvr_pkg;

  localparam int CoordW = 24;  // Q8.16 coordinate
  localparam int CfgW   = 18;  // Q2.16 cosine / sine register
  localparam int CoefW  = CfgW + 1;  // room for a negated sine
  localparam int ThrW   = 16;
  localparam int FracW  = 16;
  localparam int ProdW  = CoefW + CoordW;
  localparam int TermW  = ProdW - FracW;
  localparam int SumW   = TermW + 1;

  localparam logic signed [SumW-1:0] CoordMax = SumW'((1 << (CoordW - 1)) - 1);
  localparam logic signed [SumW-1:0] CoordMin = -SumW'(1 << (CoordW - 1));

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [CoefW-1:0]  coef_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [TermW-1:0]  term_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic [ThrW-1:0]          thr_t;

  // One plane rotation: p passes, (a, b) rotate.
  typedef struct packed {
    coord_t p;
    coord_t a;
    coord_t b;
  } vtx_t;

  // a' = c*a + k_ab*b, b' = k_ba*a + c*b
  typedef struct packed {
    coef_t c;
    coef_t k_ab;
    coef_t k_ba;
  } rot_coef_t;

  typedef enum logic [1:0] {
    CFG_COS = 2'd0,
    CFG_SIN = 2'd1,
    CFG_THR = 2'd2
  } cfg_idx_e;

  // Force small magnitudes to zero.
  function automatic term_t thr_f(input term_t v, input thr_t thr);
    term_t t;
    t = term_t'({1'b0, thr});
    if (v < t && v > -t) begin
      return '0;
    end
    return v;
  endfunction

  // Arithmetic shift by the fraction width, then threshold.
  function automatic term_t term_f(input prod_t prod, input thr_t thr);
    return thr_f(prod[ProdW-1:FracW], thr);
  endfunction

  function automatic coord_t sat_f(input sum_t s);
    sum_t r;
    if (s > CoordMax) begin
      r = CoordMax;
    end else if (s < CoordMin) begin
      r = CoordMin;
    end else begin
      r = s;
    end
    return r[CoordW-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/xvr_cfg_regs.sv
// ----------------------------------------------------------------------------
// xvr_cfg_regs
// Angle and threshold registers; derives the rotation coefficient sets.
// ----------------------------------------------------------------------------
`default_nettype none

module xvr_cfg_regs
  import xvr_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_addr_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  output rot_coef_t            coef_xz_o,
  output rot_coef_t            coef_y_o,
  output thr_t                 thr_o
);

  logic signed [CfgW-1:0] cos_q, sin_q;
  thr_t                   thr_q;
  coef_t                  cos_w, sin_w, nsin_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= CfgW'(1 << FracW);
      sin_q <= '0;
      thr_q <= ThrW'(66);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_COS: cos_q <= cfg_wdata_i;
        CFG_SIN: sin_q <= cfg_wdata_i;
        CFG_THR: thr_q <= cfg_wdata_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  assign cos_w  = {cos_q[CfgW-1], cos_q};
  assign sin_w  = {sin_q[CfgW-1], sin_q};
  assign nsin_w = -sin_w;

  // About x and about z share the same matrix shape; about y swaps the signs.
  assign coef_xz_o = '{c: cos_w, k_ab: nsin_w, k_ba: sin_w};
  assign coef_y_o  = '{c: cos_w, k_ab: sin_w,  k_ba: nsin_w};
  assign thr_o     = thr_q;

endmodule

`default_nettype wire

FILE: rtl/core/xvr_rot_stage.sv
// ----------------------------------------------------------------------------
// xvr_rot_stage
// One axis rotation in two register stages: multiply, then shift/threshold/
// sum/saturate. Elastic valid/ready per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module xvr_rot_stage
  import xvr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  rot_coef_t      coef_i,
  input  thr_t           thr_i,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  vtx_t           in_vtx_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output vtx_t           out_vtx_o
);

  logic   v1_q, v2_q;
  logic   rdy1, rdy2;
  prod_t  ca_q, cb_q, kab_q, kba_q;
  coord_t p1_q;
  vtx_t   vtx2_d, vtx2_q;
  term_t  p_t;

  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  // multiply stage; operands sign-extended to the full product width
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      ca_q  <= prod_t'(coef_i.c)    * prod_t'(in_vtx_i.a);
      kab_q <= prod_t'(coef_i.k_ab) * prod_t'(in_vtx_i.b);
      kba_q <= prod_t'(coef_i.k_ba) * prod_t'(in_vtx_i.a);
      cb_q  <= prod_t'(coef_i.c)    * prod_t'(in_vtx_i.b);
      p1_q  <= in_vtx_i.p;
    end
  end

  // sum stage; the pass-through axis sees a unit entry, so only the threshold
  always_comb begin
    p_t      = thr_f(term_t'(p1_q), thr_i);
    vtx2_d.p = p_t[CoordW-1:0];
    vtx2_d.a = sat_f(sum_t'(term_f(ca_q, thr_i)) + sum_t'(term_f(kab_q, thr_i)));
    vtx2_d.b = sat_f(sum_t'(term_f(kba_q, thr_i)) + sum_t'(term_f(cb_q, thr_i)));
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      vtx2_q <= vtx2_d;
    end
  end

  assign out_valid_o = v2_q;
  assign out_vtx_o   = vtx2_q;

endmodule

`default_nettype wire

FILE: rtl/core/xyz_vertex_rotation_core.sv
// ----------------------------------------------------------------------------
// xyz_vertex_rotation_core
// Fixed-point rotation of a vertex about x, then y, then z by one angle.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one vertex per transaction, tdata holds x, y, z
//   as signed Q8.16, 24 bits each. Output stream (m_axis_*): the rotated
//   vertex in the same packing, each coordinate saturated to 24 bits.
//   Configuration: cfg_we_i writes cos (index 0, Q2.16), sin (index 1, Q2.16)
//   or the small-product threshold (index 2). Write only while the pipeline
//   is empty; the registers feed all three rotations directly.
//   Pipeline: six register stages, two per axis (one for the four 19x24
//   multipliers, one for shift, threshold, two-term sum and saturation).
//   Throughput: one vertex per cycle while m_axis_tready is high.
//   Each register stage fills when empty, so bubbles close up under stall;
//   a stalled output holds its data and the input backs up only once all
//   six stages are full. Nothing is dropped or repeated.
//   Reset: asynchronous, active low. All stages go empty and the registers
//   return to cos = 1.0, sin = 0, threshold = 66.
// ----------------------------------------------------------------------------
`default_nettype none

module xyz_vertex_rotation_core
  import xvr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_addr_i,
  input  wire logic [CfgW-1:0]     cfg_wdata_i,
  // input vertex stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [3*CoordW-1:0] s_axis_tdata,   // x_in, y_in, z_in (low to high)
  // output vertex stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [3*CoordW-1:0]      m_axis_tdata    // x_out, y_out, z_out (low to high)
);

  rot_coef_t coef_xz, coef_y;
  thr_t      thr;

  xvr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_xz_o   (coef_xz),
    .coef_y_o    (coef_y),
    .thr_o       (thr)
  );

  coord_t x_in, y_in, z_in;
  assign x_in = s_axis_tdata[CoordW-1:0];
  assign y_in = s_axis_tdata[2*CoordW-1:CoordW];
  assign z_in = s_axis_tdata[3*CoordW-1:2*CoordW];

  // Stage about x: x passes, (y, z) rotate.
  vtx_t rx_in, rx_out;
  logic rx_valid, rx_ready;
  assign rx_in = '{p: x_in, a: y_in, b: z_in};

  xvr_rot_stage u_rot_x (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_xz),
    .thr_i       (thr),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_vtx_i    (rx_in),
    .out_valid_o (rx_valid),
    .out_ready_i (rx_ready),
    .out_vtx_o   (rx_out)
  );

  // Stage about y: y passes, (x, z) rotate with the sine signs swapped.
  vtx_t ry_in, ry_out;
  logic ry_valid, ry_ready;
  assign ry_in = '{p: rx_out.a, a: rx_out.p, b: rx_out.b};

  xvr_rot_stage u_rot_y (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_y),
    .thr_i       (thr),
    .in_valid_i  (rx_valid),
    .in_ready_o  (rx_ready),
    .in_vtx_i    (ry_in),
    .out_valid_o (ry_valid),
    .out_ready_i (ry_ready),
    .out_vtx_o   (ry_out)
  );

  // Stage about z: z passes, (x, y) rotate.
  vtx_t rz_in, rz_out;
  assign rz_in = '{p: ry_out.b, a: ry_out.a, b: ry_out.p};

  xvr_rot_stage u_rot_z (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_xz),
    .thr_i       (thr),
    .in_valid_i  (ry_valid),
    .in_ready_o  (ry_ready),
    .in_vtx_i    (rz_in),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_vtx_o   (rz_out)
  );

  assign m_axis_tdata = {rz_out.p, rz_out.b, rz_out.a};

endmodule

`default_nettype wire

FILE: rtl/core/xvr_checker.sv
// ----------------------------------------------------------------------------
// xvr_checker
// Port-level checks for the vertex rotation core.
// ----------------------------------------------------------------------------
`default_nettype none

module xvr_checker
  import xvr_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [3*CoordW-1:0] m_axis_tdata
);

  // stalled output transaction keeps its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // with the output free the pipeline moves, so the input is ready
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input blocked while output side is free");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid && s_axis_tready)
    else $error("pipeline not empty after reset");

  // an output cannot appear the cycle right after reset
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |=> !m_axis_tvalid)
    else $error("output too early after reset");

endmodule

bind xyz_vertex_rotation_core xvr_checker u_xvr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: bench/tb_xyz_vertex_rotation_core.sv
// ----------------------------------------------------------------------------
// tb_xyz_vertex_rotation_core
// Self-checking bench for the fixed-point XYZ vertex rotation core.
// Vertices stream in with random gaps while the output side stalls at random.
// Each accepted vertex is rotated by a local fixed-point predictor and the
// output stream is checked coordinate by coordinate, in order. The angle and
// the small-product threshold change between phases, only while the core is
// drained.
// ----------------------------------------------------------------------------

module tb_xyz_vertex_rotation_core;
  import xvr_pkg::*;

  localparam int     WatchdogLimit = 5000;  // cycles with no transaction at all
  localparam int     DrainCycles   = 12;    // pipeline is 6 deep, leave slack
  localparam longint QOne          = 65536; // 1.0 in Q.16
  localparam coord_t XyzMax        = coord_t'(CoordMax);
  localparam coord_t XyzMin        = coord_t'(CoordMin);

  // Packed so that x lands in the low bits of tdata.
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } vertex_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [1:0]          cfg_addr_i;
  logic [CfgW-1:0]     cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [3*CoordW-1:0] s_axis_tdata;   // x_in, y_in, z_in (low to high)
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [3*CoordW-1:0] m_axis_tdata;   // x_out, y_out, z_out (low to high)

  // Local copy of the core's registers, kept in step with every write.
  logic signed [CfgW-1:0] cos_reg;
  logic signed [CfgW-1:0] sin_reg;
  thr_t                   thr_reg;

  vertex_t vertex_backlog[$];     // vertices waiting to be sent
  vertex_t expected_vertices[$];  // rotated vertices still owed by the core

  int src_gap;
  int snk_stall;
  int src_idle_pct;
  int snk_idle_pct;
  int vertices_queued;
  int vertices_sent;
  int results_seen;
  int settings_used;
  int mismatches;
  int stuck_cycles;

  xyz_vertex_rotation_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Fixed-point rotation predictor
  // --------------------------------------------------------------------------

  // Coefficient times coordinate, shifted down by the fraction width (floor),
  // then squashed to zero when its magnitude is under the threshold.
  function automatic longint scaled_term(longint coef, longint v);
    longint p;
    longint thr;
    thr = longint'(thr_reg);
    p = (coef * v) >>> FracW;
    if (p < thr && p > -thr) begin
      p = 0;
    end
    return p;
  endfunction

  function automatic longint clamp_coord(longint s);
    if (s > longint'(CoordMax)) begin
      return longint'(CoordMax);
    end
    if (s < longint'(CoordMin)) begin
      return longint'(CoordMin);
    end
    return s;
  endfunction

  // Rotate about x, then y, then z; every stage saturates before the next.
  // The homogeneous w column is zero in the coordinate rows, so it drops out.
  function automatic vertex_t rotate_xyz(vertex_t v);
    longint  x, y, z, c, s, a, b;
    vertex_t r;
    x = v.x;
    y = v.y;
    z = v.z;
    c = cos_reg;
    s = sin_reg;
    // about x: y' = c*y - s*z, z' = s*y + c*z
    x = clamp_coord(scaled_term(QOne, x));
    a = clamp_coord(scaled_term(c, y) + scaled_term(-s, z));
    b = clamp_coord(scaled_term(s, y) + scaled_term(c, z));
    y = a;
    z = b;
    // about y: x' = c*x + s*z, z' = -s*x + c*z
    y = clamp_coord(scaled_term(QOne, y));
    a = clamp_coord(scaled_term(c, x) + scaled_term(s, z));
    b = clamp_coord(scaled_term(-s, x) + scaled_term(c, z));
    x = a;
    z = b;
    // about z: x' = c*x - s*y, y' = s*x + c*y
    z = clamp_coord(scaled_term(QOne, z));
    a = clamp_coord(scaled_term(c, x) + scaled_term(-s, y));
    b = clamp_coord(scaled_term(s, x) + scaled_term(c, y));
    r.x = coord_t'(a);
    r.y = coord_t'(b);
    r.z = coord_t'(z);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------

  // Back-to-back unless the idle percentage hits; then mostly a short gap, rarely a long one.
  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) begin
      return 0;
    end
    if ($urandom_range(99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Full-range values dominate; extremes and near-threshold values are mixed in.
  function automatic coord_t random_coord();
    case ($urandom_range(19))
      0:             return XyzMax;
      1:             return XyzMin;
      2, 3, 4, 5, 6: return coord_t'(int'($urandom_range(400)) - 200);
      default:       return coord_t'($urandom);
    endcase
  endfunction

  task automatic add_vertex(coord_t x, coord_t y, coord_t z);
    vertex_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    vertex_backlog = {vertex_backlog, v};
    vertices_queued++;
  endtask

  task automatic report_mismatch(string msg);
    $display("ERROR t=%0t result %0d: %s", $time, results_seen, msg);
    mismatches++;
  endtask

  // One register write, then a pause with we_i low, so we_i never toggles in a step.
  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes all three registers and picks new source/sink idle rates; core must be drained.
  task automatic program_angle(logic [CfgW-1:0] c, logic [CfgW-1:0] s,
                               logic [CfgW-1:0] t);
    write_reg(CFG_COS, c);
    cos_reg = c;
    write_reg(CFG_SIN, s);
    sin_reg = s;
    write_reg(CFG_THR, t);
    thr_reg = t[ThrW-1:0];
    settings_used++;
    src_idle_pct = 30 * $urandom_range(2);
    snk_idle_pct = 30 * $urandom_range(2);
  endtask

  // A random angle setting: true rotations, free pairs, unit values or raw bits.
  task automatic random_setting();
    real             ang;
    logic [CfgW-1:0] c, s, t;
    case ($urandom_range(3))
      0: begin
        ang = real'($urandom_range(35999)) * 3.14159265358979 / 18000.0;
        c = CfgW'($rtoi($cos(ang) * 65536.0));
        s = CfgW'($rtoi($sin(ang) * 65536.0));
      end
      1: begin
        c = CfgW'(int'($urandom_range(131072)) - 65536);
        s = CfgW'(int'($urandom_range(131072)) - 65536);
      end
      2: begin
        c = CfgW'(65536 * (int'($urandom_range(2)) - 1));
        s = CfgW'(65536 * (int'($urandom_range(2)) - 1));
      end
      default: begin
        c = CfgW'($urandom);
        s = CfgW'($urandom);
      end
    endcase
    // upper two bits of the threshold write are don't-care
    case ($urandom_range(7))
      0:       t = {2'($urandom_range(3)), 16'h0000};
      1:       t = {2'($urandom_range(3)), 16'hFFFF};
      2, 3:    t = {2'($urandom_range(3)), 16'($urandom)};
      default: t = {2'($urandom_range(3)), 16'($urandom_range(200))};
    endcase
    program_angle(c, s, t);
  endtask

  // Wait until every queued vertex has come back as a checked rotation.
  task automatic wait_drained();
    while (results_seen != vertices_queued)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Source driver: one vertex per transaction, random gaps between them.
  // The expected rotation is computed when the core accepts the vertex.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_proc
    vertex_t nxt;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_vertices = {expected_vertices, rotate_xyz(vertex_t'(s_axis_tdata))};
        vertices_sent++;
      end
      // hold the current vertex until it is taken
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (vertex_backlog.size() != 0) begin
          nxt = vertex_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt;
          src_gap = pick_gap(src_idle_pct);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sink monitor: in-order compare against the oldest expected rotation,
  // with random back-pressure on tready.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_proc
    vertex_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = vertex_t'(m_axis_tdata);
        if (expected_vertices.size() == 0) begin
          report_mismatch($sformatf("output with nothing pending (%0d, %0d, %0d)",
                                    got.x, got.y, got.z));
        end else begin
          want = expected_vertices.pop_front();
          if (got.x !== want.x)
            report_mismatch($sformatf("x_out %0d, expected %0d", got.x, want.x));
          if (got.y !== want.y)
            report_mismatch($sformatf("y_out %0d, expected %0d", got.y, want.y));
          if (got.z !== want.z)
            report_mismatch($sformatf("z_out %0d, expected %0d", got.z, want.z));
        end
        results_seen++;
      end
      if (snk_stall > 0) begin
        snk_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ((m_axis_tvalid && m_axis_tready) || $urandom_range(99) < 4)
          snk_stall = pick_gap(snk_idle_pct);
      end
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        stuck_cycles <= 0;
      else
        stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WatchdogLimit) begin
        $display("timeout: no transaction for %0d cycles, %0d results owed",
                 stuck_cycles, expected_vertices.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin : stim_proc
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = CFG_COS;
    cfg_wdata_i     = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    m_axis_tready   = 1'b0;
    cos_reg         = 18'sd65536;  // reset: identity rotation, threshold 66
    sin_reg         = '0;
    thr_reg         = 16'd66;
    src_gap         = 0;
    snk_stall       = 0;
    src_idle_pct    = 0;
    snk_idle_pct    = 0;
    vertices_queued = 0;
    vertices_sent   = 0;
    results_seen    = 0;
    settings_used   = 1;
    mismatches      = 0;
    stuck_cycles    = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: unit diagonal, so products equal the coordinates and only
    // the threshold alters them (65 and 1 vanish, 66 survives).
    add_vertex(0, 0, 0);
    add_vertex(XyzMax, XyzMax, XyzMax);
    add_vertex(XyzMin, XyzMin, XyzMin);
    add_vertex(XyzMax, XyzMin, 0);
    add_vertex(65, -65, 66);
    add_vertex(-66, 1, -1);
    wait_drained();

    // Quarter turn with zero threshold: cosine entries contribute nothing.
    program_angle(18'd0, 18'd65536, 18'd0);
    add_vertex(XyzMax, XyzMin, 0);
    add_vertex(1, -1, 0);
    add_vertex(4096, -8192, 12345);
    add_vertex(XyzMin, XyzMin, XyzMin);
    wait_drained();

    // cos = sin = 1.0: sums overflow and every stage saturates.
    program_angle(18'd65536, 18'd65536, 18'd66);
    add_vertex(XyzMax, XyzMax, XyzMax);
    add_vertex(XyzMin, XyzMin, XyzMin);
    add_vertex(XyzMax, XyzMin, XyzMax);
    wait_drained();

    // Negative unit entries, largest threshold; negated sine is -(-1.0).
    program_angle(-18'sd65536, -18'sd65536, 18'd65535);
    add_vertex(XyzMax, XyzMin, XyzMax);
    add_vertex(65535, -65536, 70000);
    add_vertex(0, XyzMax, XyzMin);
    wait_drained();

    // Register values beyond +-1.0 at the ends of the 18-bit range; junk in
    // the unused threshold bits.
    program_angle(18'h1FFFF, 18'h20000, 18'h30040);
    add_vertex(XyzMax, XyzMin, 12345);
    add_vertex(-1, 1, 0);
    add_vertex(XyzMin, XyzMax, -100);
    wait_drained();

    // Random part: a new angle and threshold per phase, random vertices.
    for (int p = 0; p < 8; p++) begin
      random_setting();
      for (int i = 0; i < 50; i++)
        add_vertex(random_coord(), random_coord(), random_coord());
      wait_drained();
    end

    if (expected_vertices.size() != 0)
      report_mismatch($sformatf("%0d rotated vertices never arrived",
                                expected_vertices.size()));

    $display("Sent %0d vertices, checked %0d rotations over %0d angle/threshold settings",
             vertices_sent, results_seen, settings_used);
    $display("Settings covered unit, zero, negative and out-of-range cos/sin, thresholds 0..65535");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
